// ===== rtl/core/blr_pkg.sv =====
// Shared types and constants for the byte log ring.
// Used by every module of the block but blr_ram; depends on nothing else.
package blr_pkg;

  // Ring size must be a power of two: the slot is the low bits of a position
  localparam int unsigned RING_BYTES = 16384;
  localparam int unsigned RING_AW    = $clog2(RING_BYTES);
  localparam int unsigned MAX_READ   = 64;

  localparam int unsigned POS_W  = 48;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned BYTE_W = 8;

  // Width that holds both a byte count within the ring and a read limit
  localparam int unsigned DIFF_W = (RING_AW + 1 > CNT_W) ? RING_AW + 1 : CNT_W;

  // Command queue between the front and the back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [POS_W-1:0] RING_SPAN = POS_W'(RING_BYTES);
  localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_READ);

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  from;
    logic [CNT_W-1:0]  limit;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] head;
    logic [CNT_W-1:0] cnt;
    logic             empty;
    logic             last;
  } meta_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    meta_t             meta;
  } res_t;

endpackage

// ===== rtl/core/blr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module blr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/blr_cmd_fifo.sv =====
// Short command queue between the front and the back.
// Depends on blr_pkg for the command type and depth.
module blr_cmd_fifo
  import blr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic pop_valid_o,
  output cmd_t pop_data_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  assign full_o      = (cnt_q == (QAW+1)'(QDEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/blr_front.sv =====
// Front end: takes input beats, classifies them and saturates the read limit.
// Depends on blr_pkg; feeds blr_cmd_fifo.
module blr_front
  import blr_pkg::*;
(
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [POS_W-1:0]  from_position_i,
  input  logic [CNT_W-1:0]  max_bytes_i,
  input  logic              full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify and clip the limit
  always_comb begin
    cmd_o.cmd   = command_i ? CMD_READ : CMD_APPEND;
    cmd_o.data  = data_byte_i;
    cmd_o.from  = from_position_i;
    cmd_o.limit = (max_bytes_i > LIMIT_MAX) ? LIMIT_MAX : max_bytes_i;
  end

endmodule

// ===== rtl/core/blr_back.sv =====
// Back end: owns the byte count and the ring RAM, executes appends and reads.
// Depends on blr_pkg and blr_ram; results leave through a two-entry buffer.
module blr_back
  import blr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP_LO,
    ST_CLAMP_CNT,
    ST_SET_START,
    ST_STREAM
  } state_e;

  state_e             state_q, state_d;
  logic [POS_W-1:0]   head_q, head_d;
  logic [POS_W-1:0]   start_q, start_d;
  logic [POS_W-1:0]   oldest_q, oldest_d;
  logic [CNT_W-1:0]   limit_q, limit_d;
  logic [CNT_W-1:0]   avail_q, avail_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               s1_valid_q, s1_valid_d;
  meta_t              s1_meta_q, s1_meta_d;

  logic               ram_we;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [DIFF_W-1:0]  diff;
  logic               pop;
  logic               room;

  res_t               ob_q [2];
  logic               ob_wr_q, ob_rd_q;
  logic [1:0]         ob_cnt_q;

  blr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q[RING_AW-1:0]),
    .wdata_i (cmd_i.data),
    .raddr_i (pos_q[RING_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (ob_cnt_q != 2'd0);
  assign res_o       = ob_q[ob_rd_q];

  // Issue only if the buffer can still take the beat in flight plus this one
  assign room = ({1'b0, ob_cnt_q} + {2'b00, s1_valid_q}) <= (3'd1 + {2'b00, pop});

  // Bytes between the clamped start and the head fit in the low bits
  assign diff = head_q[DIFF_W-1:0] - start_q[DIFF_W-1:0];

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // Sequencer: take or drop an append, clamp a read, then stream its bytes
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    start_d    = start_q;
    oldest_d   = oldest_q;
    limit_d    = limit_q;
    avail_d    = avail_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    s1_valid_d = 1'b0;
    s1_meta_d  = s1_meta_q;
    ram_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.cmd == CMD_APPEND) begin
            // Drop appends once the count is saturated
            if (head_q != POS_MAX) begin
              ram_we = 1'b1;
              head_d = head_q + 1'b1;
            end
          end else begin
            start_d  = (cmd_i.from > head_q) ? head_q : cmd_i.from;
            oldest_d = (head_q > RING_SPAN) ? head_q - RING_SPAN : '0;
            limit_d  = cmd_i.limit;
            state_d  = ST_CLAMP_LO;
          end
        end
      end
      ST_CLAMP_LO: begin
        // Raise a start that fell out of the ring
        if (start_q < oldest_q) begin
          start_d = oldest_q;
        end
        state_d = ST_CLAMP_CNT;
      end
      ST_CLAMP_CNT: begin
        avail_d = (diff > DIFF_W'(limit_q)) ? limit_q : diff[CNT_W-1:0];
        state_d = ST_SET_START;
      end
      ST_SET_START: begin
        // Keep the newest bytes: the run always ends just before the head
        pos_d   = head_q - POS_W'(avail_q);
        rem_d   = avail_q;
        state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (room) begin
          s1_valid_d     = 1'b1;
          s1_meta_d.head = head_q;
          s1_meta_d.cnt  = avail_q;
          s1_meta_d.pos  = pos_q;
          if (avail_q == '0) begin
            s1_meta_d.empty = 1'b1;
            s1_meta_d.last  = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            s1_meta_d.empty = 1'b0;
            s1_meta_d.last  = (rem_q == CNT_W'(1));
            pos_d           = pos_q + 1'b1;
            rem_d           = rem_q - 1'b1;
            if (rem_q == CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold sequencer state and the beat waiting on RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      start_q    <= '0;
      oldest_q   <= '0;
      limit_q    <= '0;
      avail_q    <= '0;
      rem_q      <= '0;
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_meta_q  <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      start_q    <= start_d;
      oldest_q   <= oldest_d;
      limit_q    <= limit_d;
      avail_q    <= avail_d;
      rem_q      <= rem_d;
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
      s1_meta_q  <= s1_meta_d;
    end
  end

  // Capture the result beat once read data arrives
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      ob_q[ob_wr_q].data <= s1_meta_q.empty ? '0 : ram_rdata;
      ob_q[ob_wr_q].meta <= s1_meta_q;
    end
  end

  // Advance output buffer pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      if (s1_valid_q) begin
        ob_wr_q <= !ob_wr_q;
      end
      if (pop) begin
        ob_rd_q <= !ob_rd_q;
      end
      unique case ({s1_valid_q, pop})
        2'b10:   ob_cnt_q <= ob_cnt_q + 1'b1;
        2'b01:   ob_cnt_q <= ob_cnt_q - 1'b1;
        default: ob_cnt_q <= ob_cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/byte_log_ring_with_sequence_reads.sv =====
// Byte log ring. Keeps the newest RING_BYTES bytes of a stream and a 48-bit
// count of all bytes appended (saturating; appends past the limit are
// dropped). An accepted input beat is registered in the command queue before
// the back end takes it. An append beat is written as the back end takes it.
// A read beat holds the back end while it is taken, the start is raised to
// the oldest retained byte, the length is clamped to the count and the limit
// and the first position is set; the back end then issues one result beat per
// byte, one per cycle while the output is ready, limited to the MAX_READ
// newest bytes. A read with nothing to return gives a single beat marked
// empty. Each result beat passes a RAM read stage and a two-entry output
// buffer before it is presented. The back end runs one command at a time,
// in order. A four-entry command queue lets input beats keep arriving while
// a read drains. next_position always equals the count at read time.
// Depends on blr_pkg, blr_front, blr_cmd_fifo, blr_back and blr_ram.
module byte_log_ring_with_sequence_reads
  import blr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [POS_W-1:0]  from_position_i,
  input  logic [CNT_W-1:0]  max_bytes_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [POS_W-1:0]  byte_position_o,
  output logic [POS_W-1:0]  next_position_o,
  output logic [POS_W-1:0]  head_position_o,
  output logic [CNT_W-1:0]  returned_count_o,
  output logic              empty_read_o,
  output logic              last_of_run_o
);

  logic push, full, pop, q_valid;
  cmd_t push_cmd, q_cmd;
  res_t res;

  blr_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .data_byte_i     (data_byte_i),
    .from_position_i (from_position_i),
    .max_bytes_i     (max_bytes_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  blr_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_cmd)
  );

  blr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign out_byte_o       = res.data;
  assign byte_position_o  = res.meta.pos;
  assign next_position_o  = res.meta.head;
  assign head_position_o  = res.meta.head;
  assign returned_count_o = res.meta.cnt;
  assign empty_read_o     = res.meta.empty;
  assign last_of_run_o    = res.meta.last;

endmodule
